### sv/csm_pkg.sv
package csm_pkg;

  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChSemi      = 8'h3b;
  localparam logic [7:0] ChRbrace    = 8'h7d;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdEnd  = 1'b1;

  // One queue word: up to two bytes for the back part, or an end marker.
  typedef struct packed {
    logic       is_end;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } fwd_t;

  typedef struct packed {
    logic in_string;
    logic space_pending;
    logic seen_first;
  } back_st_t;

  function automatic logic is_punct(logic [7:0] c);
    return c inside {8'h7b, 8'h7d, 8'h3b, 8'h3d, 8'h2b, 8'h2c,
                     8'h3a, 8'h2d, 8'h2f, 8'h2a, 8'h28, 8'h29};
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

endpackage

### sv/csm_in_if.sv
interface csm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] src_byte;

  modport source (output valid, output cmd, output src_byte, input ready);
  modport sink (input valid, input cmd, input src_byte, output ready);
endinterface

### sv/csm_out_if.sv
interface csm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

### sv/csm_front.sv
module csm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  csm_in_if.sink         in_i,
  input  logic           full_i,
  output logic           push_o,
  output csm_pkg::fwd_t  push_word_o
);

  logic       in_string_q, in_string_d;
  logic [7:0] prev_q, prev_d;
  logic       skip_q, skip_d;
  logic       in_dir_q, in_dir_d;
  logic       take;
  logic [7:0] c;

  assign in_i.ready = !full_i;
  assign take       = in_i.valid && !full_i;
  assign c          = in_i.src_byte;

  always_comb begin
    in_string_d = in_string_q;
    prev_d      = prev_q;
    skip_d      = skip_q;
    in_dir_d    = in_dir_q;
    push_word_o = '{is_end: 1'b0, cnt: 2'd0, b0: c, b1: csm_pkg::ChSemi};
    if (in_i.cmd == csm_pkg::CmdEnd) begin
      push_word_o.is_end = 1'b1;
      in_string_d = 1'b0;
      prev_d      = '0;
      skip_d      = 1'b0;
      in_dir_d    = 1'b0;
    end else begin
      prev_d = c;
      if (in_dir_q) begin
        if (c == csm_pkg::ChNewline) in_dir_d = 1'b0;
        push_word_o.cnt = 2'd1;
      end else if (skip_q && (csm_pkg::is_blank(c) || c == csm_pkg::ChNewline)) begin
        push_word_o.cnt = 2'd0;
      end else begin
        skip_d = 1'b0;
        push_word_o.cnt = 2'd1;
        if (c == csm_pkg::ChHash) begin
          in_dir_d = 1'b1;
        end else if (c == csm_pkg::ChQuote) begin
          in_string_d = !(in_string_q && prev_q != csm_pkg::ChBackslash);
        end else if (c == csm_pkg::ChRbrace) begin
          push_word_o.cnt = 2'd2;
          if (!in_string_q) skip_d = 1'b1;
        end else if (csm_pkg::is_punct(c)) begin
          if (!in_string_q) skip_d = 1'b1;
        end
      end
    end
  end

  // Dropped blanks send nothing down the queue.
  assign push_o = take && (push_word_o.is_end || push_word_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q <= 1'b0;
      prev_q      <= '0;
      skip_q      <= 1'b0;
      in_dir_q    <= 1'b0;
    end else if (take) begin
      in_string_q <= in_string_d;
      prev_q      <= prev_d;
      skip_q      <= skip_d;
      in_dir_q    <= in_dir_d;
    end
  end

endmodule

### sv/csm_fifo.sv
module csm_fifo #(
  parameter int Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  csm_pkg::fwd_t  push_word_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output csm_pkg::fwd_t  pop_word_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] DepthCnt = CW'(Depth);

  csm_pkg::fwd_t mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o     = (cnt_q == DepthCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_word_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_word_i;
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt) else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
`endif

endmodule

### sv/csm_back.sv
module csm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  csm_pkg::fwd_t  word_i,
  output logic           pop_o,
  csm_out_if.source      out_o
);

  typedef struct packed {
    csm_pkg::back_st_t st;
    logic [1:0]        n;
    logic [7:0]        o0;
    logic [7:0]        o1;
  } take_res_t;

  function automatic take_res_t back_take(csm_pkg::back_st_t s, logic [7:0] c);
    take_res_t r;
    r.st = s;
    r.n  = 2'd1;
    r.o0 = c;
    r.o1 = c;
    if (!s.seen_first) begin
      r.st.seen_first = 1'b1;
    end else if (!s.in_string && csm_pkg::is_blank(c)) begin
      r.st.space_pending = 1'b1;
      r.n = 2'd0;
    end else if (s.space_pending) begin
      r.st.space_pending = 1'b0;
      if (!csm_pkg::is_punct(c)) begin
        r.n  = 2'd2;
        r.o0 = csm_pkg::ChSpace;
      end
    end
    if (r.n != 2'd0 && c == csm_pkg::ChQuote) r.st.in_string = !s.in_string;
    return r;
  endfunction

  csm_pkg::back_st_t st_q, st_d;
  logic       busy_q, busy_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic [7:0] res_q [3];
  logic [7:0] res_d [3];
  take_res_t  r0, r1;
  logic [2:0] k;
  logic       is_last, last_taken;

  assign is_last          = (idx_q == cnt_q - 2'd1);
  assign last_taken       = busy_q && out_o.ready && is_last;
  assign pop_o            = valid_i && (!busy_q || last_taken);
  assign out_o.valid      = busy_q;
  assign out_o.out_byte   = res_q[idx_q];
  assign out_o.last_of_run = is_last;

  always_comb begin
    r0 = back_take(st_q, word_i.b0);
    r1 = back_take(r0.st, word_i.b1);
    res_d = res_q;
    st_d  = st_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    k      = 3'd0;
    if (busy_q && out_o.ready) begin
      if (is_last) busy_d = 1'b0;
      else idx_d = idx_q + 2'd1;
    end
    if (pop_o) begin
      idx_d = 2'd0;
      if (word_i.is_end) begin
        res_d[0] = csm_pkg::ChNewline;
        k    = 3'd1;
        st_d = '0;
      end else begin
        if (r0.n == 2'd2) begin
          res_d[k[1:0]] = r0.o0;
          k = k + 3'd1;
        end
        if (r0.n != 2'd0) begin
          res_d[k[1:0]] = r0.o1;
          k = k + 3'd1;
        end
        st_d = r0.st;
        if (word_i.cnt == 2'd2) begin
          // second byte of a word is always after a brace, so k stays below three
          if (r1.n == 2'd2) begin
            res_d[k[1:0]] = r1.o0;
            k = k + 3'd1;
          end
          if (r1.n != 2'd0) begin
            res_d[k[1:0]] = r1.o1;
            k = k + 3'd1;
          end
          st_d = r1.st;
        end
      end
      cnt_d  = k[1:0];
      busy_d = (k != 3'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      busy_q <= 1'b0;
      cnt_q  <= '0;
      idx_q  <= '0;
    end else begin
      st_q   <= st_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

`ifndef ASSERT_OFF
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != 2'd0 && idx_q < cnt_q)) else $error("word index past run");
`endif

endmodule

### sv/c_source_whitespace_minifier_core.sv
// channel  | dir | payload                         | handshake
// in_i     | in  | cmd[0], src_byte[7:0]           | valid/ready
// out_o    | out | out_byte[7:0], last_of_run[0]   | valid/ready
//
// One input word per cycle while the queue has room; result words are
// sent from the back part's output register, one word per ready cycle.
// A source byte yields zero to two words, an end word exactly one ('\n').
// The front part stalls only when the queue (QueueDepth words) is full;
// the back part stalls on out_o.ready alone.
// Reset (rst_ni low, async) empties the queue and clears control state.
module c_source_whitespace_minifier_core #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csm_in_if.sink     in_i,
  csm_out_if.source  out_o
);

  logic          push, full, pop, q_valid;
  csm_pkg::fwd_t push_word, pop_word;

  csm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .push_word_o (push_word)
  );

  csm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_word_o  (pop_word)
  );

  csm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .word_i  (pop_word),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
